// File: rtl/kvt_pkg.sv
// Shared types and codes for the key/value table.
`default_nettype none

package kvt_pkg;

  // Request kinds
  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_LOOKUP = 2'd1;
  localparam logic [1:0] ACT_REMOVE = 2'd2;

  localparam int unsigned KEY_W   = 32;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_W = 5;

  // Request word
  typedef struct packed {
    logic [1:0]                action;
    logic signed [KEY_W-1:0]   key;
    logic [VALUE_W-1:0]        value_in;
  } req_t;

  // Response word
  typedef struct packed {
    logic                      hit;
    logic [VALUE_W-1:0]        value_out;
    logic [COUNT_W-1:0]        entry_count;
    logic                      table_full;
  } rsp_t;

  // Controller commands to the datapath
  typedef struct packed {
    logic capture;  // take a request word and latch the compare results
    logic commit;   // update the table and load the response register
  } cmd_t;

endpackage

`default_nettype wire

// File: rtl/kvt_ctrl.sv
// Controller: request handshake, two-state sequencer and response valid.
`default_nettype none

module kvt_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output kvt_pkg::cmd_t      cmd_o
);

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_COMMIT = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic capture, commit, slot_free;

  // Take a new word only while idle
  assign in_stall_o = (state_q != ST_IDLE);
  assign capture    = in_valid_i && !in_stall_o;

  // Commit once the response register is free or being emptied
  assign slot_free = !out_valid_q || !out_stall_i;
  assign commit    = (state_q == ST_COMMIT) && slot_free;

  // Advance the sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (capture) state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (commit) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Hold the response until taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (commit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign cmd_o.capture = capture;
  assign cmd_o.commit  = commit;

endmodule

`default_nettype wire

// File: rtl/kvt_datapath.sv
// Datapath: key compare array, valid marks, entry count, value memory, response register.
`default_nettype none

module kvt_datapath #(
  parameter int unsigned ENTRIES = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire kvt_pkg::req_t in_i,
  input  wire kvt_pkg::cmd_t cmd_i,
  output kvt_pkg::rsp_t      out_o
);

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);

  // Entry storage
  logic [kvt_pkg::KEY_W-1:0]   keys_q   [ENTRIES];
  logic [kvt_pkg::VALUE_W-1:0] values_q [ENTRIES];
  logic [ENTRIES-1:0]          valid_q;
  logic [CNT_W-1:0]            count_q;

  // Captured request and search results
  kvt_pkg::req_t               req_q;
  logic                        match_any_q;
  logic [IDX_W-1:0]            match_idx_q;
  logic                        free_any_q;
  logic [IDX_W-1:0]            free_idx_q;

  // Response register
  logic                        hit_q;
  logic                        vsel_q;
  logic                        full_q;
  logic [kvt_pkg::VALUE_W-1:0] rd_q;

  logic [ENTRIES-1:0]          match_vec;
  logic [ENTRIES-1:0]          free_oh;
  logic [IDX_W-1:0]            match_idx;
  logic [IDX_W-1:0]            free_idx;
  logic [IDX_W-1:0]            wr_idx;
  logic                        is_insert, is_lookup, is_remove;
  logic                        do_fill, do_update, do_free;
  logic [CNT_W+kvt_pkg::COUNT_W-1:0] count_ext;

  // Compare the key against every valid entry
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match_vec[i] = valid_q[i] && (keys_q[i] == $unsigned(in_i.key));
    end
  end

  // Isolate the lowest free entry
  assign free_oh = ~valid_q & (valid_q + ENTRIES'(1));

  // Encode both vectors; each has at most one bit set
  always_comb begin
    match_idx = '0;
    free_idx  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (match_vec[i]) match_idx = match_idx | IDX_W'(i);
      if (free_oh[i])   free_idx  = free_idx  | IDX_W'(i);
    end
  end

  // Latch request and search results on capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q       <= in_i;
      match_any_q <= |match_vec;
      match_idx_q <= match_idx;
      free_any_q  <= ~&valid_q;
      free_idx_q  <= free_idx;
    end
  end

  // Decode the pending operation
  assign is_insert = (req_q.action == kvt_pkg::ACT_INSERT);
  assign is_lookup = (req_q.action == kvt_pkg::ACT_LOOKUP);
  assign is_remove = (req_q.action == kvt_pkg::ACT_REMOVE);
  assign do_update = cmd_i.commit && is_insert && match_any_q;
  assign do_fill   = cmd_i.commit && is_insert && !match_any_q && free_any_q;
  assign do_free   = cmd_i.commit && is_remove && match_any_q;
  assign wr_idx    = match_any_q ? match_idx_q : free_idx_q;

  // Write a new key into the free entry
  always_ff @(posedge clk_i) begin
    if (do_fill) begin
      keys_q[free_idx_q] <= $unsigned(req_q.key);
    end
  end

  // Value memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (do_update || do_fill) begin
      values_q[wr_idx] <= req_q.value_in;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && is_lookup) begin
      rd_q <= values_q[match_idx_q];
    end
  end

  // Valid marks and entry count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      count_q <= '0;
    end else begin
      if (do_fill) begin
        valid_q[free_idx_q] <= 1'b1;
        count_q             <= count_q + CNT_W'(1);
      end else if (do_free) begin
        valid_q[match_idx_q] <= 1'b0;
        count_q              <= count_q - CNT_W'(1);
      end
    end
  end

  // Load the response flags on commit
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      hit_q  <= match_any_q && (is_insert || is_lookup || is_remove);
      vsel_q <= match_any_q && is_lookup;
      full_q <= is_insert && !match_any_q && !free_any_q;
    end
  end

  assign count_ext = (CNT_W + kvt_pkg::COUNT_W)'(count_q);

  assign out_o.hit         = hit_q;
  assign out_o.value_out   = vsel_q ? rd_q : '0;
  assign out_o.entry_count = count_ext[kvt_pkg::COUNT_W-1:0];
  assign out_o.table_full  = full_q;

endmodule

`default_nettype wire

// File: rtl/key_value_table_core.sv
// Top level of the content addressable key/value table.
//
//   channel | direction | word            | handshake
//   --------+-----------+-----------------+----------------------
//   in      | input     | kvt_pkg::req_t  | in_valid_i / in_stall_o
//   out     | output    | kvt_pkg::rsp_t  | out_valid_o / out_stall_i
//
// Each request is handled in order: the accept edge latches the parallel key
// compare over all entries, the commit edge updates the table and loads the
// response register. A new request is taken in the cycle after that.
// Reset clears all valid marks and the entry count at once; no sweep.
// While the response register is full and stalled, the commit step waits.
`default_nettype none

module key_value_table_core #(
  parameter int unsigned ENTRIES = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire kvt_pkg::req_t in_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output kvt_pkg::rsp_t      out_o
);

  kvt_pkg::cmd_t cmd;

  // Sequencer and handshake
  kvt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // Table storage and response
  kvt_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .cmd_i  (cmd),
    .out_o  (out_o)
  );

endmodule

`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench for the key/value table core with a built-in table predictor.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned TABLE_ENTRIES = 16;
  localparam int unsigned KEY_POOL      = 24;
  localparam int unsigned RANDOM_WORDS  = 650;
  localparam int unsigned CYCLE_LIMIT   = 300000;
  localparam logic [1:0]  ACT_UNUSED    = 2'd3;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_CHOPPY,
    STALL_HELD
  } stall_mode_e;

  // Mirror of the table: predicts the response word for every request taken
  class kvt_table_model;
    logic [kvt_pkg::KEY_W-1:0]   key_store   [TABLE_ENTRIES];
    logic [kvt_pkg::VALUE_W-1:0] value_store [TABLE_ENTRIES];
    bit                          slot_used   [TABLE_ENTRIES];
    int unsigned                 used_count;
    kvt_pkg::rsp_t               due_rsp[$];
    int unsigned                 errors;

    function new();
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      used_count = 0;
      errors     = 0;
    endfunction

    task report_mismatch(string what);
      errors++;
      $display("%0t ns: response mismatch: %s", $time, what);
    endtask

    // Update the mirror and queue the response word the request must give
    task apply_request(kvt_pkg::req_t req);
      kvt_pkg::rsp_t want;
      int            match_slot;
      int            free_slot;
      want       = '0;
      match_slot = -1;
      free_slot  = -1;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (slot_used[i] && key_store[i] == req.key && match_slot < 0) match_slot = i;
        if (!slot_used[i] && free_slot < 0) free_slot = i;
      end
      case (req.action)
        kvt_pkg::ACT_INSERT: begin
          if (match_slot >= 0) begin
            value_store[match_slot] = req.value_in;
            want.hit = 1'b1;
          end else if (free_slot >= 0) begin
            key_store[free_slot]   = req.key;
            value_store[free_slot] = req.value_in;
            slot_used[free_slot]   = 1'b1;
            used_count++;
          end else begin
            want.table_full = 1'b1;
          end
        end
        kvt_pkg::ACT_LOOKUP: begin
          if (match_slot >= 0) begin
            want.hit       = 1'b1;
            want.value_out = value_store[match_slot];
          end
        end
        kvt_pkg::ACT_REMOVE: begin
          if (match_slot >= 0) begin
            slot_used[match_slot] = 1'b0;
            if (used_count > 0) used_count--;
            want.hit = 1'b1;
          end
        end
        default: ;
      endcase
      want.entry_count = used_count[kvt_pkg::COUNT_W-1:0];
      due_rsp.push_back(want);
    endtask

    // Compare a delivered response word with the oldest one due
    task match_response(kvt_pkg::rsp_t got);
      kvt_pkg::rsp_t want;
      if (due_rsp.size() == 0) begin
        report_mismatch($sformatf("word %h with none due", got));
        return;
      end
      want = due_rsp.pop_front();
      if (got.hit !== want.hit)
        report_mismatch($sformatf("hit %b, want %b", got.hit, want.hit));
      if (got.value_out !== want.value_out)
        report_mismatch($sformatf("value_out %h, want %h", got.value_out, want.value_out));
      if (got.entry_count !== want.entry_count)
        report_mismatch($sformatf("entry_count %0d, want %0d",
                                  got.entry_count, want.entry_count));
      if (got.table_full !== want.table_full)
        report_mismatch($sformatf("table_full %b, want %b", got.table_full, want.table_full));
    endtask
  endclass

  logic          clk_i       = 1'b0;
  logic          rst_ni      = 1'b0;
  logic          in_valid_i  = 1'b0;
  logic          in_stall_o;
  kvt_pkg::req_t in_i        = '0;
  logic          out_valid_o;
  logic          out_stall_i = 1'b0;
  kvt_pkg::rsp_t out_o;

  kvt_table_model            table_model;
  logic [kvt_pkg::KEY_W-1:0] key_pool [KEY_POOL];
  int unsigned               burst_left = 0;
  stall_mode_e               stall_mode = STALL_NONE;
  int unsigned               mode_left  = 0;
  int unsigned               cycle_count = 0;

  key_value_table_core #(
    .ENTRIES(TABLE_ENTRIES)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_o      (out_o)
  );

  always #4 clk_i = ~clk_i;

  // Receiver: switch between free flow, random stalls and held stalls
  always @(posedge clk_i) begin
    if (mode_left == 0) begin
      stall_mode <= stall_mode_e'($urandom_range(2, 0));
      mode_left  <= $urandom_range(40, 4);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      STALL_NONE:   out_stall_i <= 1'b0;
      STALL_CHOPPY: out_stall_i <= 1'($urandom_range(1, 0));
      default:      out_stall_i <= 1'b1;
    endcase
  end

  // Check every response word taken from the block
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      table_model.match_response(out_o);
    end
  end

  // Abort a hung run
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("** key_value_table_core: FAILED **");
    $finish;
  end

  function automatic kvt_pkg::req_t make_req(logic [1:0] action,
                                             logic [kvt_pkg::KEY_W-1:0] key,
                                             logic [kvt_pkg::VALUE_W-1:0] value);
    kvt_pkg::req_t req;
    req.action   = action;
    req.key      = key;
    req.value_in = value;
    return req;
  endfunction

  // Drive one request word in bursts with random gaps; hold it until taken
  task automatic send_word(kvt_pkg::req_t req);
    if (burst_left == 0) begin
      int unsigned gap;
      gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(20, 1);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_i       <= req;
    do @(posedge clk_i); while (in_stall_o);
    table_model.apply_request(req);
  endtask

  function automatic logic [kvt_pkg::KEY_W-1:0] pick_key();
    if ($urandom_range(99, 0) < 85) return key_pool[$urandom_range(KEY_POOL - 1, 0)];
    return $urandom;
  endfunction

  function automatic logic [kvt_pkg::VALUE_W-1:0] pick_value();
    case ($urandom_range(9, 0))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [1:0] pick_action(bit filling);
    int unsigned roll;
    roll = $urandom_range(99, 0);
    if (roll < 5) return ACT_UNUSED;
    if (filling) begin
      if (roll < 60) return kvt_pkg::ACT_INSERT;
      if (roll < 85) return kvt_pkg::ACT_LOOKUP;
      return kvt_pkg::ACT_REMOVE;
    end
    if (roll < 25) return kvt_pkg::ACT_INSERT;
    if (roll < 55) return kvt_pkg::ACT_LOOKUP;
    return kvt_pkg::ACT_REMOVE;
  endfunction

  initial begin
    table_model = new();
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7FFF_FFFF;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hFFFF_FFFF;
    for (int i = 4; i < KEY_POOL; i++) key_pool[i] = $urandom;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Misses on the empty table
    send_word(make_req(kvt_pkg::ACT_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF));
    send_word(make_req(kvt_pkg::ACT_REMOVE, 32'h8000_0000, 32'h0000_0000));
    // Fill every slot, key and value extremes first
    send_word(make_req(kvt_pkg::ACT_INSERT, 32'h8000_0000, 32'h0000_0000));
    send_word(make_req(kvt_pkg::ACT_INSERT, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
    send_word(make_req(kvt_pkg::ACT_INSERT, 32'h0000_0000, 32'h3F80_0000));
    send_word(make_req(kvt_pkg::ACT_INSERT, 32'hFFFF_FFFF, 32'h7F80_0000));
    for (int i = 4; i < TABLE_ENTRIES; i++) begin
      send_word(make_req(kvt_pkg::ACT_INSERT, 32'h0000_1000 + i, $urandom));
    end
    // New key into a full table is refused, a present key still updates
    send_word(make_req(kvt_pkg::ACT_INSERT, 32'h1234_5678, 32'hDEAD_BEEF));
    send_word(make_req(kvt_pkg::ACT_INSERT, 32'h7FFF_FFFF, 32'h5555_AAAA));
    send_word(make_req(kvt_pkg::ACT_LOOKUP, 32'h7FFF_FFFF, 32'h0000_0000));
    send_word(make_req(kvt_pkg::ACT_LOOKUP, 32'h1234_5678, 32'h0000_0000));
    // Free a middle slot, ignore the unused code, refill the lowest free slot
    send_word(make_req(kvt_pkg::ACT_REMOVE, 32'h0000_0000, 32'hFFFF_FFFF));
    send_word(make_req(ACT_UNUSED, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
    send_word(make_req(kvt_pkg::ACT_INSERT, 32'h1234_5678, 32'hDEAD_BEEF));

    // Random traffic over a small key pool, alternating fill and drain phases
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      send_word(make_req(pick_action(((n / 100) % 2) == 0), pick_key(), pick_value()));
    end
    in_valid_i <= 1'b0;

    // Drain outstanding responses, then watch for stray words
    while (table_model.due_rsp.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (table_model.errors == 0) begin
      $display("** key_value_table_core: PASSED **");
    end else begin
      $display("** key_value_table_core: FAILED **");
    end
    $finish;
  end

endmodule
